### design/fixed_point_q24_8_alu_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Q24.8 ALU
// Implication checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_TOP_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_MACROS_SVH

// Same-cycle implication
`define FPALU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FPALU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// fpalu_pkg
// Operation codes shared by the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

	typedef logic [3:0] kind_t;

	localparam kind_t OP_ADD      = 4'd0;
	localparam kind_t OP_SUB      = 4'd1;
	localparam kind_t OP_MUL      = 4'd2;
	localparam kind_t OP_DIV      = 4'd3;
	localparam kind_t OP_CMP      = 4'd4;
	localparam kind_t OP_MIN      = 4'd5;
	localparam kind_t OP_MAX      = 4'd6;
	localparam kind_t OP_INC      = 4'd7;
	localparam kind_t OP_DEC      = 4'd8;
	localparam kind_t OP_FROM_INT = 4'd9;
	localparam kind_t OP_TO_INT   = 4'd10;

endpackage

### design/fixed_point_q24_8_alu_top.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Signed fixed-point ALU with saturation, rounding multiply and divide.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, kind, operand_a/b     | in
//  out     | out_valid, out_ready, result, flags       | out
//
//  The pipe depth is set by the restoring divider, which resolves one
//  quotient bit per stage. One transfer is taken every cycle while the
//  output is not stalled; all operations share the same pipe, so results
//  leave in order.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  A stall at the output holds the whole pipe, bubbles included; the pipe
//  advances in every cycle in which the last stage is empty or drained.
// ----------------------------------------------------------------------------
`include "fixed_point_q24_8_alu_top_macros.svh"

module fixed_point_q24_8_alu_top #(
	parameter int FRACTION_BITS = 8,
	parameter int WORD_WIDTH    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  fpalu_pkg::kind_t              kind,
	input  logic signed [WORD_WIDTH-1:0]  operand_a,
	input  logic signed [WORD_WIDTH-1:0]  operand_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [WORD_WIDTH-1:0]  result,
	output logic                          a_greater,
	output logic                          a_less,
	output logic                          a_equal,
	output logic                          overflow,
	output logic                          divide_by_zero
);
	import fpalu_pkg::*;

	localparam int W  = WORD_WIDTH;
	localparam int F  = FRACTION_BITS;
	// quotient bits: dividend 2*(|a|<<F) + |b| needs W+F+1 bits
	localparam int NW = W + F + 1;
	// decode stage, NW divide steps, final stage
	localparam int S  = NW + 2;

	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	// pipeline state, index is the stage number
	logic          v_s    [1:S];
	kind_t         kind_s [1:S];
	logic [W-1:0]  r_s    [1:S];
	logic          ovf_s  [1:S];
	logic          dz_s   [1:S];
	logic          gt_s   [1:S];
	logic          lt_s   [1:S];
	logic          eq_s   [1:S];
	logic          neg_s  [1:S];
	logic [W:0]    rem_s  [1:S];
	logic [NW-1:0] nq_s   [1:S];
	logic [W:0]    den_s  [1:S];
	logic [W-1:0]  ma_s1, mb_s1;
	logic [2*W-1:0] prod_s2;

	logic en;

	// advance whenever the last stage is empty or being drained
	assign en       = !v_s[S] || out_ready;
	assign in_ready = en;

	// ---------------------------------------------------------------- stage 1
	// decode, compare, and all single-step operations
	logic [W-1:0]   mag_a, mag_b;
	logic [W:0]     sum_x, dif_x;
	logic [W+F-1:0] shl_x;
	logic [W-1:0]   r_d;
	logic           ovf_d, gt_d, lt_d, eq_d;

	always_comb begin
		mag_a = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
		mag_b = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;
		sum_x = {operand_a[W-1], operand_a} + {operand_b[W-1], operand_b};
		dif_x = {operand_a[W-1], operand_a} - {operand_b[W-1], operand_b};
		shl_x = {{F{operand_a[W-1]}}, operand_a} << F;
		gt_d  = operand_a > operand_b;
		lt_d  = operand_a < operand_b;
		eq_d  = operand_a == operand_b;
		r_d   = '0;
		ovf_d = 1'b0;
		case (kind)
			OP_ADD: begin
				ovf_d = sum_x[W] != sum_x[W-1];
				r_d   = ovf_d ? (sum_x[W] ? MIN_V : MAX_V) : sum_x[W-1:0];
			end
			OP_SUB: begin
				ovf_d = dif_x[W] != dif_x[W-1];
				r_d   = ovf_d ? (dif_x[W] ? MIN_V : MAX_V) : dif_x[W-1:0];
			end
			OP_MIN: r_d = lt_d ? operand_a : operand_b;
			OP_MAX: r_d = gt_d ? operand_a : operand_b;
			OP_INC: begin
				ovf_d = operand_a == MAX_V;
				r_d   = ovf_d ? MAX_V : operand_a + 1'b1;
			end
			OP_DEC: begin
				ovf_d = operand_a == MIN_V;
				r_d   = ovf_d ? MIN_V : operand_a - 1'b1;
			end
			OP_FROM_INT: begin
				// overflow when the bits above the result word are not a sign copy
				ovf_d = (shl_x[W+F-1:W-1] != '0) && (shl_x[W+F-1:W-1] != '1);
				r_d   = ovf_d ? (operand_a[W-1] ? MIN_V : MAX_V) : shl_x[W-1:0];
			end
			OP_TO_INT: r_d = operand_a >>> F;
			default:   r_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[1] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s[1] <= kind;
			r_s[1]    <= r_d;
			ovf_s[1]  <= ovf_d;
			dz_s[1]   <= 1'b0;
			gt_s[1]   <= gt_d;
			lt_s[1]   <= lt_d;
			eq_s[1]   <= eq_d;
			neg_s[1]  <= operand_a[W-1] ^ operand_b[W-1];
			rem_s[1]  <= '0;
			nq_s[1]   <= {mag_a, {F{1'b0}}, 1'b0} + NW'(mag_b);
			den_s[1]  <= {mag_b, 1'b0};
			ma_s1     <= mag_a;
			mb_s1     <= mag_b;
		end
	end

	// product of magnitudes, registered before rounding
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ma_s1 * mb_s1;
		end
	end

	// ------------------------------------------------------- stages 2 to S
	for (genvar i = 2; i <= S; i++) begin : g_stage
		logic [W+1:0]   trial;
		logic           qbit;
		logic [W:0]     rem_n;
		logic [NW-1:0]  nq_n;
		logic [W-1:0]   r_n;
		logic           ovf_n, dz_n;
		logic [2*W-1:0] rnd;

		always_comb begin
			trial = {rem_s[i-1], nq_s[i-1][NW-1]};
			qbit  = trial >= {1'b0, den_s[i-1]};
			rem_n = qbit ? (W+1)'(trial - {1'b0, den_s[i-1]}) : trial[W:0];
			nq_n  = {nq_s[i-1][NW-2:0], qbit};
			r_n   = r_s[i-1];
			ovf_n = ovf_s[i-1];
			dz_n  = dz_s[i-1];
			rnd   = (prod_s2 + (2*W)'(1 << (F - 1))) >> F;
			if (i == 3 && kind_s[i-1] == OP_MUL) begin
				// round half away from zero, then saturate
				if (neg_s[i-1]) begin
					ovf_n = rnd > (2*W)'(MIN_V);
					r_n   = ovf_n ? MIN_V : W'(~rnd + 1'b1);
				end else begin
					ovf_n = rnd > (2*W)'(MAX_V);
					r_n   = ovf_n ? MAX_V : rnd[W-1:0];
				end
			end
			if (i == S && kind_s[i-1] == OP_DIV) begin
				if (den_s[i-1] == '0) begin
					dz_n  = 1'b1;
					ovf_n = 1'b0;
					r_n   = '0;
				end else if (neg_s[i-1]) begin
					ovf_n = nq_s[i-1] > NW'(MIN_V);
					r_n   = ovf_n ? MIN_V : W'(~nq_s[i-1] + 1'b1);
				end else begin
					ovf_n = nq_s[i-1] > NW'(MAX_V);
					r_n   = ovf_n ? MAX_V : nq_s[i-1][W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				kind_s[i] <= kind_s[i-1];
				r_s[i]    <= r_n;
				ovf_s[i]  <= ovf_n;
				dz_s[i]   <= dz_n;
				gt_s[i]   <= gt_s[i-1];
				lt_s[i]   <= lt_s[i-1];
				eq_s[i]   <= eq_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				// hold the divider state once all quotient bits are in
				rem_s[i]  <= (i <= NW + 1) ? rem_n : rem_s[i-1];
				nq_s[i]   <= (i <= NW + 1) ? nq_n : nq_s[i-1];
				den_s[i]  <= den_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------- outputs
	assign out_valid      = v_s[S];
	assign result         = r_s[S];
	assign a_greater      = gt_s[S];
	assign a_less         = lt_s[S];
	assign a_equal        = eq_s[S];
	assign overflow       = ovf_s[S];
	assign divide_by_zero = dz_s[S];

	// ---------------------------------------------------------- assertions
	`FPALU_ASSERT_IMP(a_cmp_onehot, out_valid, $onehot({a_greater, a_less, a_equal}), "compare flags not one-hot")
	`FPALU_ASSERT_IMP(a_dz_zero, out_valid && divide_by_zero, result == '0 && !overflow, "divide by zero result not clean")
	`FPALU_ASSERT_NXT(a_stall_hold, v_s[S] && !out_ready, v_s[S] && $stable(kind_s[S]), "stalled stage changed")

endmodule
